// ===== src/qat_pkg.sv =====
`timescale 1ns / 1ps

package qat_pkg;

    localparam int MAX_LINE = 256;
    localparam int MAX_ARGS = 64;
    localparam int POS_W    = $clog2(MAX_LINE);
    localparam int CNT_W    = $clog2(MAX_ARGS + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        CL_ZERO,
        CL_BLANK,
        CL_ESC,
        CL_QUOTE,
        CL_BANG,
        CL_OTHER
    } char_class_t;

    typedef enum logic [2:0] {
        S_BETWEEN,
        S_IN_ARG,
        S_ESCAPE,
        S_QUOTE,
        S_DONE
    } scan_mode_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_REST
    } token_phase_t;

    typedef struct packed {
        logic [7:0]       ch;
        char_class_t      cls;
        logic [POS_W-1:0] pos;
        logic             drop;
    } qat_entry_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       arg_end;
        logic [5:0] arg_index;
        logic       alt_start;
        logic [7:0] alt_pos;
        logic       line_end;
        logic [6:0] arg_count;
        logic       alt_valid;
        logic       overflow;
    } qat_result_t;

endpackage

// ===== src/quoted_argument_tokenizer.sv =====
`timescale 1ns / 1ps

// A byte accepted by the front end is written into a queue slot, and the back
// end then pops it from there into the output register that drives the result.
// Throughput: one byte per cycle when not stalled; the scan state steps per byte.
// The two-entry queue lets input and output stall independently.
// Reset (rst_n low, asynchronous) empties the queue and output and returns the
// scanner to the start of a line; each terminator does the same for line state.

module quoted_argument_tokenizer
    import qat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       char_valid,
    output logic [7:0] out_char,
    output logic       arg_end,
    output logic [5:0] arg_index,
    output logic       alt_start,
    output logic [7:0] alt_pos,
    output logic       line_end,
    output logic [6:0] arg_count,
    output logic       alt_valid,
    output logic       overflow
);

    logic        push;
    logic        queue_full;
    logic        pop;
    logic        not_empty;
    qat_entry_t  push_entry;
    qat_entry_t  pop_entry;
    qat_result_t res;

    qat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    qat_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .pop_entry  (pop_entry)
    );

    qat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .entry     (pop_entry),
        .pop       (pop),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign char_valid = res.char_valid;
    assign out_char   = res.out_char;
    assign arg_end    = res.arg_end;
    assign arg_index  = res.arg_index;
    assign alt_start  = res.alt_start;
    assign alt_pos    = res.alt_pos;
    assign line_end   = res.line_end;
    assign arg_count  = res.arg_count;
    assign alt_valid  = res.alt_valid;
    assign overflow   = res.overflow;

endmodule

// ===== src/qat_front.sv =====
`timescale 1ns / 1ps

module qat_front
    import qat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    output logic       push,
    output qat_entry_t push_entry,
    input  logic       queue_full
);

    logic [POS_W-1:0] line_pos_reg;
    logic [POS_W-1:0] line_pos_next;
    logic             at_limit;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;
    assign at_limit = (line_pos_reg >= POS_W'(MAX_LINE - 1));

    always_comb
    begin
        push_entry.ch   = ch;
        push_entry.pos  = line_pos_reg;
        push_entry.drop = (ch != CH_NUL) && at_limit;
        if (ch == CH_NUL)
            push_entry.cls = CL_ZERO;
        else if (ch == CH_SPACE || ch == CH_TAB)
            push_entry.cls = CL_BLANK;
        else if (ch == CH_BSLASH)
            push_entry.cls = CL_ESC;
        else if (ch == CH_QUOTE)
            push_entry.cls = CL_QUOTE;
        else if (ch == CH_BANG || ch == CH_DOLLAR)
            push_entry.cls = CL_BANG;
        else
            push_entry.cls = CL_OTHER;
    end

    // offset of the next raw byte; held at the limit once the line is too long
    always_comb
    begin
        line_pos_next = line_pos_reg;
        if (push)
        begin
            if (ch == CH_NUL)
                line_pos_next = '0;
            else if (!at_limit)
                line_pos_next = line_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_pos_reg <= '0;
        else
            line_pos_reg <= line_pos_next;
    end

endmodule

// ===== src/qat_fifo.sv =====
`timescale 1ns / 1ps

module qat_fifo
    import qat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  qat_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output qat_entry_t pop_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    qat_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;

    assign full      = (level_reg == LVL_W'(QUEUE_DEPTH));
    assign not_empty = (level_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            level_next = level_reg + 1'b1;
        else if (pop && !push)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== src/qat_back.sv =====
`timescale 1ns / 1ps

module qat_back
    import qat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        not_empty,
    input  qat_entry_t  entry,
    output logic        pop,
    output logic        res_valid,
    input  logic        res_ready,
    output qat_result_t res
);

    scan_mode_t       mode_reg;
    scan_mode_t       mode_next;
    token_phase_t     phase_reg;
    token_phase_t     phase_next;
    logic             got_reg;
    logic             got_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [POS_W-1:0] aoff_reg;
    logic [POS_W-1:0] aoff_next;
    logic             aseen_reg;
    logic             aseen_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             res_valid_reg;
    qat_result_t      res_reg;
    qat_result_t      res_next;

    logic             is_zero;
    logic             args_full;
    logic             bang_first;

    assign pop        = not_empty && (!res_valid_reg || res_ready);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;
    assign is_zero    = (entry.cls == CL_ZERO);
    assign args_full  = (cnt_reg >= CNT_W'(MAX_ARGS));
    assign bang_first = (entry.pos == '0) && (phase_reg == PH_FIRST) && (entry.cls == CL_BANG);

    // scan mode
    always_comb
    begin
        mode_next = mode_reg;
        if (is_zero)
            mode_next = S_BETWEEN;
        else if (!entry.drop)
        begin
            case (mode_reg)
                S_BETWEEN:
                begin
                    if (bang_first || entry.cls == CL_BLANK)
                        mode_next = S_BETWEEN;
                    else if (args_full)
                        mode_next = S_DONE;
                    else if (entry.cls == CL_ESC)
                        mode_next = S_ESCAPE;
                    else if (entry.cls == CL_QUOTE)
                        mode_next = S_QUOTE;
                    else
                        mode_next = S_IN_ARG;
                end
                S_IN_ARG:
                begin
                    if (entry.cls == CL_BLANK)
                        mode_next = got_reg ? S_BETWEEN : S_DONE;
                    else if (entry.cls == CL_ESC)
                        mode_next = S_ESCAPE;
                    else if (entry.cls == CL_QUOTE)
                        mode_next = S_QUOTE;
                end
                S_ESCAPE: mode_next = S_IN_ARG;
                S_QUOTE:
                begin
                    if (entry.cls == CL_QUOTE)
                        mode_next = S_IN_ARG;
                end
                S_DONE:  mode_next = S_DONE;
                default: mode_next = S_BETWEEN;
            endcase
        end
    end

    // counters, flags and the result word
    always_comb
    begin
        res_next    = '0;
        phase_next  = phase_reg;
        got_next    = got_reg;
        cnt_next    = cnt_reg;
        aoff_next   = aoff_reg;
        aseen_next  = aseen_reg;
        ovf_next    = ovf_reg;
        res_next.arg_index = 6'(cnt_reg);

        if (is_zero)
        begin
            res_next.line_end = 1'b1;
            if (mode_reg != S_DONE)
            begin
                if (mode_reg != S_BETWEEN && got_reg)
                begin
                    res_next.arg_end = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    got_next = 1'b0;
                end
                if (phase_reg == PH_FIRST)
                    phase_next = PH_SECOND;
                else if (phase_reg == PH_SECOND)
                begin
                    phase_next = PH_REST;
                    aseen_next = 1'b0;
                    aoff_next  = '0;
                end
            end
        end
        else if (entry.drop)
            ovf_next = 1'b1;
        else
        begin
            case (mode_reg)
                S_BETWEEN:
                begin
                    if (bang_first)
                    begin
                        phase_next          = PH_SECOND;
                        res_next.char_valid = 1'b1;
                        res_next.out_char   = entry.ch;
                        res_next.arg_end    = 1'b1;
                        cnt_next            = cnt_reg + 1'b1;
                        got_next            = 1'b0;
                    end
                    else if (entry.cls == CL_BLANK)
                        got_next = got_reg;
                    else if (args_full)
                        ovf_next = 1'b1;
                    else
                    begin
                        if (phase_reg == PH_FIRST)
                            phase_next = PH_SECOND;
                        else if (phase_reg == PH_SECOND)
                        begin
                            phase_next         = PH_REST;
                            aoff_next          = entry.pos;
                            aseen_next         = 1'b1;
                            res_next.alt_start = 1'b1;
                        end
                        got_next = 1'b0;
                        if (entry.cls != CL_ESC && entry.cls != CL_QUOTE)
                        begin
                            res_next.char_valid = 1'b1;
                            res_next.out_char   = entry.ch;
                            got_next            = 1'b1;
                        end
                    end
                end
                S_IN_ARG:
                begin
                    if (entry.cls == CL_BLANK)
                    begin
                        if (got_reg)
                        begin
                            res_next.arg_end = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                            got_next = 1'b0;
                        end
                    end
                    else if (entry.cls != CL_ESC && entry.cls != CL_QUOTE)
                    begin
                        res_next.char_valid = 1'b1;
                        res_next.out_char   = entry.ch;
                        got_next            = 1'b1;
                    end
                end
                S_ESCAPE:
                begin
                    res_next.char_valid = 1'b1;
                    res_next.out_char   = entry.ch;
                    got_next            = 1'b1;
                end
                S_QUOTE:
                begin
                    if (entry.cls != CL_QUOTE)
                    begin
                        res_next.char_valid = 1'b1;
                        res_next.out_char   = entry.ch;
                        got_next            = 1'b1;
                    end
                end
                default: got_next = got_reg;
            endcase
        end

        res_next.arg_count = 7'(cnt_next);
        res_next.alt_valid = aseen_next;
        res_next.alt_pos   = aseen_next ? 8'(aoff_next) : 8'h00;
        res_next.overflow  = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= S_BETWEEN;
            phase_reg     <= PH_FIRST;
            got_reg       <= 1'b0;
            cnt_reg       <= '0;
            aoff_reg      <= '0;
            aseen_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                res_valid_reg <= 1'b1;
                if (is_zero)
                begin
                    // line done: back to the start-of-line state
                    mode_reg  <= S_BETWEEN;
                    phase_reg <= PH_FIRST;
                    got_reg   <= 1'b0;
                    cnt_reg   <= '0;
                    aoff_reg  <= '0;
                    aseen_reg <= 1'b0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    mode_reg  <= mode_next;
                    phase_reg <= phase_next;
                    got_reg   <= got_next;
                    cnt_reg   <= cnt_next;
                    aoff_reg  <= aoff_next;
                    aseen_reg <= aseen_next;
                    ovf_reg   <= ovf_next;
                end
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ARGS))
        else $error("argument count beyond limit");

    a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && is_zero |=> cnt_reg == '0 && phase_reg == PH_FIRST && !aseen_reg && !ovf_reg)
        else $error("line state not cleared after terminator");

    a_alt_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.alt_start |-> res_reg.alt_valid && !res_reg.line_end)
        else $error("second argument start without alt_valid");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");
`endif

endmodule
